>>> src/dtpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtpc_pkg;

  // Width of the tick counters. They wrap at this width.
  localparam int COUNT_BITS = 16;
  localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [15:0] len_t;
  typedef logic [7:0] time_t;
  typedef logic [2:0] phase_t;
  typedef logic [2:0] reg_idx_t;

  // Configuration register indexes.
  localparam reg_idx_t REG_PERIOD    = 3'd0;
  localparam reg_idx_t REG_BLINK     = 3'd1;
  localparam reg_idx_t REG_INIT_TIME = 3'd2;
  localparam reg_idx_t REG_OFF_PULSE = 3'd3;
  localparam reg_idx_t REG_OFF_GAP   = 3'd4;
  localparam reg_idx_t REG_ON_PULSE  = 3'd5;
  localparam reg_idx_t REG_ON_GAP    = 3'd6;

  // Pulse sequence phases.
  localparam phase_t PH_OFF     = 3'd0;
  localparam phase_t PH_OFF_GAP = 3'd1;
  localparam phase_t PH_ON      = 3'd2;
  localparam phase_t PH_ON_GAP  = 3'd3;
  localparam phase_t PH_IDLE    = 3'd4;

  localparam len_t  PERIOD_RESET    = 16'd64000;
  localparam len_t  BLINK_RESET     = 16'd5000;
  localparam time_t INIT_TIME_RESET = 8'd1;
  localparam len_t  OFF_PULSE_RESET = 16'd2000;
  localparam len_t  OFF_GAP_RESET   = 16'd100;
  localparam len_t  ON_PULSE_RESET  = 16'd1000;
  localparam len_t  ON_GAP_RESET    = 16'd540;
  localparam time_t TIME_STEP       = 8'd10;
  localparam time_t TIME_MIN        = 8'd1;

  typedef struct packed {
    len_t            period_ticks;
    len_t            blink_ticks;
    logic [3:0][15:0] pulse_len;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pilot_off;
    logic pilot_on;
  } pulse_sts_t;

  function automatic cnt_t cnt_inc(input cnt_t c);
    return cnt_t'(c + cnt_t'(1));
  endfunction

  function automatic logic cnt_eq(input cnt_t c, input len_t v);
    return CMP_W'(c) == CMP_W'(v);
  endfunction

  function automatic logic cnt_ge(input cnt_t c, input len_t v);
    return CMP_W'(c) >= CMP_W'(v);
  endfunction

  // Division by ten for an 8-bit value via reciprocal multiply.
  function automatic time_t div10(input time_t x);
    logic [15:0] p;
    p = 16'(x) * 16'd205;
    return time_t'(p[15:11]);
  endfunction

endpackage

`default_nettype wire

>>> src/dtpc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpc_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire dtpc_pkg::reg_idx_t cfg_index,
  input  wire logic [15:0]       cfg_data,
  output dtpc_pkg::cfg_t         cfg,
  output logic                   time_load,
  output dtpc_pkg::time_t        time_value
);
  import dtpc_pkg::*;

  logic wr;

  assign cfg_ready  = 1'b1;
  assign wr         = cfg_valid && cfg_ready;
  // A write of the initial time also reloads the held time.
  assign time_load  = wr && (cfg_index == REG_INIT_TIME);
  assign time_value = cfg_data[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= PERIOD_RESET;
      cfg.blink_ticks  <= BLINK_RESET;
      cfg.pulse_len[0] <= OFF_PULSE_RESET;
      cfg.pulse_len[1] <= OFF_GAP_RESET;
      cfg.pulse_len[2] <= ON_PULSE_RESET;
      cfg.pulse_len[3] <= ON_GAP_RESET;
    end else if (wr) begin
      unique case (cfg_index)
        REG_PERIOD:    cfg.period_ticks <= cfg_data;
        REG_BLINK:     cfg.blink_ticks  <= cfg_data;
        REG_OFF_PULSE: cfg.pulse_len[0] <= cfg_data;
        REG_OFF_GAP:   cfg.pulse_len[1] <= cfg_data;
        REG_ON_PULSE:  cfg.pulse_len[2] <= cfg_data;
        REG_ON_GAP:    cfg.pulse_len[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/dtpc_pulse.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpc_pulse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick,
  input  wire logic             start,
  input  wire dtpc_pkg::cfg_t   cfg,
  output dtpc_pkg::pulse_sts_t  sts
);
  import dtpc_pkg::*;

  phase_t pulse_phase, pulse_phase_next, eff;
  cnt_t   pulse_count, pulse_count_next, cnt_inc_v, cnt_base;
  len_t   cur_len;

  // Skip phases of zero length before this tick's work.
  always_comb begin
    eff = pulse_phase;
    for (int i = 0; i < 4; i++) begin
      if (eff == phase_t'(i) && cfg.pulse_len[i] == '0) begin
        eff = phase_t'(i + 1);
      end
    end
    if (eff > PH_IDLE) begin
      eff = PH_IDLE;
    end
  end

  // A skipped phase leaves the count at zero for the phase that follows.
  assign cnt_base      = (eff == pulse_phase) ? pulse_count : '0;
  assign cur_len       = cfg.pulse_len[eff[1:0]];
  assign cnt_inc_v     = cnt_inc(cnt_base);
  assign sts.busy      = (eff != PH_IDLE);
  assign sts.pilot_off = (eff == PH_OFF);
  assign sts.pilot_on  = (eff == PH_ON);

  always_comb begin
    pulse_phase_next = pulse_phase;
    pulse_count_next = pulse_count;
    if (tick) begin
      if (sts.busy) begin
        if (cnt_ge(cnt_inc_v, cur_len)) begin
          pulse_phase_next = eff + 3'd1;
          pulse_count_next = '0;
        end else begin
          pulse_phase_next = eff;
          pulse_count_next = cnt_inc_v;
        end
      end else begin
        pulse_phase_next = start ? PH_OFF : PH_IDLE;
        pulse_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_phase <= PH_OFF;
      pulse_count <= '0;
    end else begin
      pulse_phase <= pulse_phase_next;
      pulse_count <= pulse_count_next;
    end
  end

endmodule

`default_nettype wire

>>> src/dtpc_led.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpc_led (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire dtpc_pkg::time_t held_time,
  input  wire dtpc_pkg::cfg_t  cfg,
  output logic                 led_next
);
  import dtpc_pkg::*;

  logic  blink_running, blink_running_next;
  logic  blink_lit_phase, blink_lit_phase_next;
  time_t blink_index, blink_index_next;
  cnt_t  wait_or_lit_count, wait_or_lit_count_next;
  cnt_t  dark_count, dark_count_next;
  logic  led_register;
  time_t limit;

  // Number of blinks minus one: the tens digit of the held time minus one (zero for a held time of zero).
  assign limit = (held_time == '0) ? '0 : div10(held_time - 8'd1);

  always_comb begin
    blink_running_next     = blink_running;
    blink_lit_phase_next   = blink_lit_phase;
    blink_index_next       = blink_index;
    wait_or_lit_count_next = wait_or_lit_count;
    dark_count_next        = dark_count;
    led_next               = led_register;
    if (step) begin
      if (blink_running) begin
        if (blink_index <= limit) begin
          if (blink_lit_phase) begin
            led_next               = 1'b1;
            wait_or_lit_count_next = cnt_inc(wait_or_lit_count);
            if (cnt_eq(wait_or_lit_count_next, cfg.blink_ticks)) begin
              wait_or_lit_count_next = '0;
              blink_lit_phase_next   = 1'b0;
            end
          end else begin
            led_next        = 1'b0;
            dark_count_next = cnt_inc(dark_count);
            if (cnt_eq(dark_count_next, cfg.blink_ticks)) begin
              dark_count_next      = '0;
              blink_lit_phase_next = 1'b1;
              blink_index_next     = blink_index + 8'd1;
            end
          end
        end else begin
          blink_running_next     = 1'b0;
          blink_index_next       = '0;
          wait_or_lit_count_next = '0;
          dark_count_next        = '0;
        end
      end else begin
        led_next               = 1'b0;
        wait_or_lit_count_next = cnt_inc(wait_or_lit_count);
        if (cnt_eq(wait_or_lit_count_next, cfg.period_ticks)) begin
          blink_running_next     = 1'b1;
          wait_or_lit_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_running     <= 1'b0;
      blink_lit_phase   <= 1'b0;
      blink_index       <= '0;
      wait_or_lit_count <= '0;
      dark_count        <= '0;
      led_register      <= 1'b1;
    end else begin
      blink_running     <= blink_running_next;
      blink_lit_phase   <= blink_lit_phase_next;
      blink_index       <= blink_index_next;
      wait_or_lit_count <= wait_or_lit_count_next;
      dark_count        <= dark_count_next;
      led_register      <= led_next;
    end
  end

endmodule

`default_nettype wire

>>> src/door_timed_power_cycler.sv
// Door timed power cycler.
// Input channel (in_valid/in_stall) carries one main-loop tick per transaction:
// door_pin, barman_pin and button_pin, all active low. Output channel
// (out_valid/out_stall) returns exactly one result per tick: LED level, pilot
// off/on levels, countdown and sequence flags, and the save request with the
// held time.
// Each tick is processed by the state logic and lands in the output register;
// its result is valid from the cycle after it is accepted. A tick can be
// accepted every cycle unless the receiver stalls: in_stall rises only while
// a result sits in the output register and the receiver stalls; the next tick
// is taken in the same cycle the waiting result leaves.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; writing the initial time also reloads the held time.
// After reset the registers hold their default lengths and the pilot pulse
// sequence starts at once with the off pulse; ticks during the sequence
// ignore the pins.
`timescale 1ns / 1ps
`default_nettype none

module door_timed_power_cycler (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              door_pin,
  input  wire logic              barman_pin,
  input  wire logic              button_pin,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   led_level,
  output logic                   pilot_off,
  output logic                   pilot_on,
  output logic                   countdown_active,
  output logic                   sequence_busy,
  output logic                   save_strobe,
  output logic [7:0]             save_value,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire dtpc_pkg::reg_idx_t cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import dtpc_pkg::*;

  cfg_t       cfg;
  logic       time_load;
  time_t      time_value;
  pulse_sts_t psts;
  logic       accept, step, led_next;

  logic  door_armed, door_armed_next;
  logic  door_open, door_open_next;
  logic  barman_seen, barman_seen_next;
  logic  button_held, button_held_next;
  time_t held_time, held_time_next;
  cnt_t  period_count, period_count_next;
  time_t period_tally, period_tally_next;
  logic  save, start;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign step     = accept && !psts.busy;

  dtpc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .time_load  (time_load),
    .time_value (time_value)
  );

  dtpc_pulse u_pulse (
    .clk   (clk),
    .rst   (rst),
    .tick  (accept),
    .start (start),
    .cfg   (cfg),
    .sts   (psts)
  );

  dtpc_led u_led (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .held_time (held_time),
    .cfg       (cfg),
    .led_next  (led_next)
  );

  always_comb begin
    door_armed_next   = door_armed;
    door_open_next    = door_open;
    barman_seen_next  = barman_seen;
    button_held_next  = button_held;
    held_time_next    = held_time;
    period_count_next = period_count;
    period_tally_next = period_tally;
    save              = 1'b0;
    start             = 1'b0;
    if (step) begin
      if (!door_pin && !door_open) begin
        door_armed_next = 1'b1;
        door_open_next  = 1'b1;
      end
      if (door_pin && door_open) begin
        door_open_next = 1'b0;
      end
      // The barman coming back cancels the countdown once the door is shut.
      if (!barman_pin && barman_seen && !door_open_next) begin
        door_armed_next  = 1'b0;
        barman_seen_next = 1'b0;
      end
      if (barman_pin && !barman_seen) begin
        barman_seen_next = 1'b1;
      end
      if (!button_pin && !button_held) begin
        button_held_next = 1'b1;
        if (barman_pin) begin
          held_time_next = held_time + TIME_STEP;
        end else begin
          held_time_next = TIME_MIN;
          save           = 1'b1;
        end
      end
      if (button_pin && button_held) begin
        button_held_next = 1'b0;
        save             = 1'b1;
      end
      if (door_armed_next) begin
        period_count_next = cnt_inc(period_count);
        if (cnt_eq(period_count_next, cfg.period_ticks)) begin
          period_count_next = '0;
          period_tally_next = period_tally + 8'd1;
          if (period_tally_next >= held_time_next) begin
            period_tally_next = '0;
            door_armed_next   = 1'b0;
            start             = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      door_armed   <= 1'b0;
      door_open    <= 1'b0;
      barman_seen  <= 1'b0;
      button_held  <= 1'b0;
      held_time    <= INIT_TIME_RESET;
      period_count <= '0;
      period_tally <= '0;
    end else begin
      door_armed   <= door_armed_next;
      door_open    <= door_open_next;
      barman_seen  <= barman_seen_next;
      button_held  <= button_held_next;
      held_time    <= time_load ? time_value : held_time_next;
      period_count <= period_count_next;
      period_tally <= period_tally_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_level        <= led_next;
      pilot_off        <= psts.pilot_off;
      pilot_on         <= psts.pilot_on;
      countdown_active <= door_armed_next;
      sequence_busy    <= psts.busy;
      save_strobe      <= save;
      save_value       <= held_time_next;
    end
  end

  a_pilot_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pilot_off && pilot_on))
    else $error("pilot off and on driven together");

  a_pilot_only_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sequence_busy) |-> (!pilot_off && !pilot_on))
    else $error("pilot pulse outside the sequence");

  a_busy_no_save: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sequence_busy) |-> !save_strobe)
    else $error("save requested during the pulse sequence");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire
